[rtl/core/strided_subvolume_extract_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the strided subvolume extractor
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STRIDED_SUBVOLUME_EXTRACT_MACROS_SVH
`define STRIDED_SUBVOLUME_EXTRACT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSVE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSVE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ssve_pkg.sv]
// ----------------------------------------------------------------------------
// Strided subvolume extractor package
// Widths, register indexes, reset values and shared types of the block.
// ----------------------------------------------------------------------------
package ssve_pkg;

    // Grid counter, summary count, size and window register widths.
    localparam int POS_W   = 11;
    localparam int PHASE_W = 10;
    localparam int CNT_W   = 11;
    localparam int SIZE_W  = 11;
    localparam int WIN_W   = 32;

    // Saturation value of the x position counter and the picked counts.
    localparam logic [POS_W-1:0] POS_MAX = 11'd2047;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_Z = 3'd4;

    // Register reset values: 50 points per axis, window start 0, end 50, step 1.
    localparam logic [SIZE_W-1:0] SIZE_RESET   = 11'd50;
    localparam logic [WIN_W-1:0]  WINDOW_RESET = 32'd4296704;

    // Result kinds.
    localparam logic KIND_POINT   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Depth of the queue between the classifier and the result stage.
    localparam int QUEUE_DEPTH = 4;

    // Classification of one queued item.
    typedef struct packed {
        logic hit;
        logic last;
        logic bump_x;
        logic bump_y;
        logic bump_z;
    } tag_t;

    // Result stage: first result of the head item, or its pending summary.
    typedef enum logic {
        BK_FIRST,
        BK_SUMMARY
    } back_state_t;

endpackage

[rtl/core/ssve_fifo.sv]
// ----------------------------------------------------------------------------
// Strided subvolume extractor queue
// Small register queue that decouples the classifier from the result stage.
// ----------------------------------------------------------------------------
module ssve_fifo #(
    parameter int WIDTH = 101,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             valid
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    // Status and head of the queue.
    assign full    = (count_reg == CW'(DEPTH));
    assign valid   = (count_reg != '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

`include "strided_subvolume_extract_macros.svh"

    `SSVE_ASSERT_IMP(a_count_max, 1'b1, count_reg <= CW'(DEPTH), "queue count above depth")
    `SSVE_ASSERT_NEXT(a_count_track, 1'b1, count_reg == CW'($past(count_reg) + CW'($past(do_push)) - CW'($past(do_pop))), "queue count lost an item")

endmodule

[rtl/core/ssve_front.sv]
// ----------------------------------------------------------------------------
// Strided subvolume extractor classifier
// Holds the configuration, follows the grid position of each incoming item
// and decides whether it is picked, queueing items that cause a result.
// ----------------------------------------------------------------------------
module ssve_front #(
    parameter int MAX_GRID = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ssve_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssve_pkg::WIN_W-1:0]          cfg_data,
    input  logic                                s_tvalid,
    input  logic                                s_tlast,
    output logic                                s_tready,
    input  logic                                q_full,
    output logic                                q_push,
    output ssve_pkg::tag_t                      q_tag
);

    localparam int POS_W   = ssve_pkg::POS_W;
    localparam int PHASE_W = ssve_pkg::PHASE_W;
    localparam logic [POS_W:0] GRID_LIM = (POS_W + 1)'(MAX_GRID);

    // Window register layout, highest field first.
    typedef struct packed {
        logic [PHASE_W-1:0] step;
        logic [POS_W-1:0]   stop;
        logic [POS_W-1:0]   start;
    } window_t;

    logic [ssve_pkg::SIZE_W-1:0] size_y_reg;
    logic [ssve_pkg::SIZE_W-1:0] size_z_reg;
    window_t                     window_x_reg;
    window_t                     window_y_reg;
    window_t                     window_z_reg;

    logic [POS_W-1:0]   pos_x_reg,   pos_y_reg,   pos_z_reg;
    logic [PHASE_W-1:0] phase_x_reg, phase_y_reg, phase_z_reg;
    logic [POS_W-1:0]   pos_x_next,  pos_y_next,  pos_z_next;
    logic [PHASE_W-1:0] phase_x_next, phase_y_next, phase_z_next;

    logic [POS_W:0] lim_y;
    logic [POS_W:0] lim_z;
    logic [POS_W:0] nx, ny, nz;
    logic           hit_x, hit_y, hit_z;
    logic           accept;

    // A size of zero acts as one; a size above the grid limit is clamped.
    function automatic logic [POS_W:0] eff_size(input logic [ssve_pkg::SIZE_W-1:0] s);
        logic [POS_W:0] w;
        w = (POS_W + 1)'(s);
        if (s == '0)
        begin
            return (POS_W + 1)'(1);
        end
        return (w > GRID_LIM) ? GRID_LIM : w;
    endfunction

    // In the window, below the clamped end and on a step boundary.
    function automatic logic axis_hit(input logic [POS_W-1:0] pos,
                                      input logic [PHASE_W-1:0] ph,
                                      input window_t w,
                                      input logic [POS_W:0] lim);
        logic [POS_W:0] stop_c;
        stop_c = ({1'b0, w.stop} > lim) ? lim : {1'b0, w.stop};
        return (pos >= w.start) && ({1'b0, pos} < stop_c) && (ph == '0);
    endfunction

    // Step phase once the position has moved past the window start.
    function automatic logic [PHASE_W-1:0] next_phase(input logic [POS_W:0] newpos,
                                                      input logic [PHASE_W-1:0] ph,
                                                      input window_t w);
        logic [PHASE_W:0]   n;
        logic [PHASE_W-1:0] st;
        st = (w.step == '0) ? PHASE_W'(1) : w.step;
        n  = {1'b0, ph} + 1'b1;
        if (newpos <= {1'b0, w.start})
        begin
            return '0;
        end
        return (n >= {1'b0, st}) ? '0 : n[PHASE_W-1:0];
    endfunction

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Classification of the current grid position.
    always_comb
    begin
        lim_y = eff_size(size_y_reg);
        lim_z = eff_size(size_z_reg);
        hit_x = axis_hit(pos_x_reg, phase_x_reg, window_x_reg, GRID_LIM);
        hit_y = axis_hit(pos_y_reg, phase_y_reg, window_y_reg, lim_y);
        hit_z = axis_hit(pos_z_reg, phase_z_reg, window_z_reg, lim_z);

        q_tag.hit    = hit_x && hit_y && hit_z;
        q_tag.last   = s_tlast;
        q_tag.bump_x = (pos_y_reg == window_y_reg.start) && (pos_z_reg == window_z_reg.start);
        q_tag.bump_y = (pos_x_reg == window_x_reg.start) && (pos_z_reg == window_z_reg.start);
        q_tag.bump_z = (pos_x_reg == window_x_reg.start) && (pos_y_reg == window_y_reg.start);

        // Only picked items and the last item produce results.
        q_push = accept && (q_tag.hit || s_tlast);
    end

    // Raster position advance: z fastest, then y, then x.
    always_comb
    begin
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        pos_z_next   = pos_z_reg;
        phase_x_next = phase_x_reg;
        phase_y_next = phase_y_reg;
        phase_z_next = phase_z_reg;
        nx = {1'b0, pos_x_reg} + 1'b1;
        ny = {1'b0, pos_y_reg} + 1'b1;
        nz = {1'b0, pos_z_reg} + 1'b1;
        if (accept)
        begin
            if (s_tlast)
            begin
                pos_x_next   = '0;
                pos_y_next   = '0;
                pos_z_next   = '0;
                phase_x_next = '0;
                phase_y_next = '0;
                phase_z_next = '0;
            end
            else if (nz < lim_z)
            begin
                phase_z_next = next_phase(nz, phase_z_reg, window_z_reg);
                pos_z_next   = nz[POS_W-1:0];
            end
            else
            begin
                pos_z_next   = '0;
                phase_z_next = '0;
                if (ny < lim_y)
                begin
                    phase_y_next = next_phase(ny, phase_y_reg, window_y_reg);
                    pos_y_next   = ny[POS_W-1:0];
                end
                else
                begin
                    pos_y_next   = '0;
                    phase_y_next = '0;
                    // The x position holds once it saturates.
                    if (pos_x_reg < ssve_pkg::POS_MAX)
                    begin
                        phase_x_next = next_phase(nx, phase_x_reg, window_x_reg);
                        pos_x_next   = nx[POS_W-1:0];
                    end
                end
            end
        end
    end

    // Grid counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            pos_z_reg   <= '0;
            phase_x_reg <= '0;
            phase_y_reg <= '0;
            phase_z_reg <= '0;
        end
        else
        begin
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            pos_z_reg   <= pos_z_next;
            phase_x_reg <= phase_x_next;
            phase_y_reg <= phase_y_next;
            phase_z_reg <= phase_z_next;
        end
    end

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_y_reg   <= ssve_pkg::SIZE_RESET;
            size_z_reg   <= ssve_pkg::SIZE_RESET;
            window_x_reg <= window_t'(ssve_pkg::WINDOW_RESET);
            window_y_reg <= window_t'(ssve_pkg::WINDOW_RESET);
            window_z_reg <= window_t'(ssve_pkg::WINDOW_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ssve_pkg::CFG_SIZE_Y:   size_y_reg   <= cfg_data[ssve_pkg::SIZE_W-1:0];
                ssve_pkg::CFG_SIZE_Z:   size_z_reg   <= cfg_data[ssve_pkg::SIZE_W-1:0];
                ssve_pkg::CFG_WINDOW_X: window_x_reg <= window_t'(cfg_data);
                ssve_pkg::CFG_WINDOW_Y: window_y_reg <= window_t'(cfg_data);
                ssve_pkg::CFG_WINDOW_Z: window_z_reg <= window_t'(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

`include "strided_subvolume_extract_macros.svh"

    `SSVE_ASSERT_NEXT(a_volume_clear, accept && s_tlast, (pos_x_reg == '0) && (pos_y_reg == '0) && (pos_z_reg == '0), "grid position not cleared after the last item")

endmodule

[rtl/core/ssve_back.sv]
// ----------------------------------------------------------------------------
// Strided subvolume extractor result stage
// Turns queued items into results, keeps the bounding box and picked counts,
// and drives the registered output item.
// ----------------------------------------------------------------------------
module ssve_back #(
    parameter int COORD_BITS = 32
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          q_valid,
    input  logic [3*COORD_BITS-1:0]                       q_pts,
    input  ssve_pkg::tag_t                                q_tag,
    output logic                                          q_pop,
    input  logic                                          m_tready,
    output logic                                          m_tvalid,
    output logic                                          m_kind,
    output logic                                          m_run_end,
    output logic [6*COORD_BITS+3*ssve_pkg::CNT_W-1:0]     m_payload
);

    localparam int CB    = COORD_BITS;
    localparam int CNT_W = ssve_pkg::CNT_W;

    ssve_pkg::back_state_t state_reg, state_next;

    logic [CB-1:0]    low_reg  [3];
    logic [CB-1:0]    high_reg [3];
    logic [CNT_W-1:0] cnt_reg  [3];
    logic             any_reg;
    logic [CB-1:0]    low_next  [3];
    logic [CB-1:0]    high_next [3];
    logic [CNT_W-1:0] cnt_next  [3];
    logic             any_next;

    logic             m_tvalid_reg, m_tvalid_next;
    logic             m_kind_reg, m_kind_next;
    logic             m_run_end_reg, m_run_end_next;
    logic [CB-1:0]    val_reg  [3];
    logic [CB-1:0]    top_reg  [3];
    logic [CNT_W-1:0] pick_reg [3];
    logic [CB-1:0]    val_next  [3];
    logic [CB-1:0]    top_next  [3];
    logic [CNT_W-1:0] pick_next [3];

    logic [CB-1:0]    pt [3];
    logic [2:0]       bump;
    logic             load;
    logic             emit_point;

    assign pt[0] = q_pts[CB-1:0];
    assign pt[1] = q_pts[2*CB-1:CB];
    assign pt[2] = q_pts[3*CB-1:2*CB];
    assign bump  = {q_tag.bump_z, q_tag.bump_y, q_tag.bump_x};

    // A new result enters when the output register is free or being taken.
    assign load       = q_valid && (!m_tvalid_reg || m_tready);
    assign emit_point = q_tag.hit && (state_reg == ssve_pkg::BK_FIRST);

    // Next state: a picked last item leaves its summary pending.
    always_comb
    begin
        state_next = state_reg;
        if (load)
        begin
            if (emit_point && q_tag.last)
            begin
                state_next = ssve_pkg::BK_SUMMARY;
            end
            else
            begin
                state_next = ssve_pkg::BK_FIRST;
            end
        end
    end

    // Outputs of the sequencer: the head leaves once its final result is out.
    always_comb
    begin
        q_pop = load && !(emit_point && q_tag.last);
    end

    // Bounding box, counts and the output item.
    always_comb
    begin
        any_next       = any_reg;
        m_kind_next    = m_kind_reg;
        m_run_end_next = m_run_end_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        for (int i = 0; i < 3; i++)
        begin
            low_next[i]  = low_reg[i];
            high_next[i] = high_reg[i];
            cnt_next[i]  = cnt_reg[i];
            val_next[i]  = val_reg[i];
            top_next[i]  = top_reg[i];
            pick_next[i] = pick_reg[i];
        end
        if (load)
        begin
            m_tvalid_next = 1'b1;
            if (emit_point)
            begin
                m_kind_next    = ssve_pkg::KIND_POINT;
                m_run_end_next = !q_tag.last;
                any_next       = 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    val_next[i]  = pt[i];
                    top_next[i]  = '0;
                    pick_next[i] = '0;
                    if (!any_reg || ($signed(pt[i]) < $signed(low_reg[i])))
                    begin
                        low_next[i] = pt[i];
                    end
                    if (!any_reg || ($signed(high_reg[i]) < $signed(pt[i])))
                    begin
                        high_next[i] = pt[i];
                    end
                    if (bump[i] && (cnt_reg[i] < ssve_pkg::POS_MAX))
                    begin
                        cnt_next[i] = cnt_reg[i] + 1'b1;
                    end
                end
            end
            else
            begin
                // Summary of the volume, then everything clears.
                m_kind_next    = ssve_pkg::KIND_SUMMARY;
                m_run_end_next = 1'b1;
                any_next       = 1'b0;
                for (int i = 0; i < 3; i++)
                begin
                    val_next[i]  = low_reg[i];
                    top_next[i]  = high_reg[i];
                    pick_next[i] = cnt_reg[i];
                    low_next[i]  = '0;
                    high_next[i] = '0;
                    cnt_next[i]  = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ssve_pkg::BK_FIRST;
            any_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                low_reg[i]  <= '0;
                high_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            any_reg      <= any_next;
            m_tvalid_reg <= m_tvalid_next;
            for (int i = 0; i < 3; i++)
            begin
                low_reg[i]  <= low_next[i];
                high_reg[i] <= high_next[i];
                cnt_reg[i]  <= cnt_next[i];
            end
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge clk)
    begin
        m_kind_reg    <= m_kind_next;
        m_run_end_reg <= m_run_end_next;
        for (int i = 0; i < 3; i++)
        begin
            val_reg[i]  <= val_next[i];
            top_reg[i]  <= top_next[i];
            pick_reg[i] <= pick_next[i];
        end
    end

    assign m_tvalid  = m_tvalid_reg;
    assign m_kind    = m_kind_reg;
    assign m_run_end = m_run_end_reg;
    assign m_payload = {pick_reg[2], pick_reg[1], pick_reg[0],
                        top_reg[2], top_reg[1], top_reg[0],
                        val_reg[2], val_reg[1], val_reg[0]};

`include "strided_subvolume_extract_macros.svh"

    `SSVE_ASSERT_IMP(a_summary_head, state_reg == ssve_pkg::BK_SUMMARY, q_valid && q_tag.hit && q_tag.last, "pending summary without a picked last item at the head")
    `SSVE_ASSERT_IMP(a_summary_ends_run, m_tvalid_reg && (m_kind_reg == ssve_pkg::KIND_SUMMARY), m_run_end_reg, "summary item not marked as the end of its run")

endmodule

[rtl/core/strided_subvolume_extract.sv]
// ----------------------------------------------------------------------------
// Strided subvolume extractor
// Picks the grid points inside a strided 3D window and reports their
// bounding box and per-axis picked counts at the end of each volume.
// ----------------------------------------------------------------------------
// Grid points enter on the s_ channel in raster order (z fastest, then y,
// then x); s_tlast marks the last point of the volume. Each picked point
// leaves on the m_ channel as a point item (m_tuser low). After the last
// point a summary item (m_tuser high) carries the minima, maxima and picked
// counts, and all grid and bounding state clears for the next volume.
// m_tlast is high on the last item caused by an input point.
// One point is accepted per cycle while the queue is not full. A point that
// causes a result enters the queue when accepted, then the output register.
// The result stage emits one item per cycle while m_tready is high, so a
// picked last point, which causes two items, holds the queue head until its
// summary loads; the four-entry queue absorbs this and output stalls.
// When m_tready is low the output item holds and the queue fills; s_tready
// drops only once the queue is full. Reset clears the grid position, bounds
// and counts, empties the queue and loads the default registers (50 by 50
// points, windows 0 to 50, step 1). Registers are written through cfg_we,
// cfg_index, cfg_data by the user only while idle; the block does not check.
// ----------------------------------------------------------------------------
module strided_subvolume_extract #(
    parameter int MAX_GRID   = 1024,
    parameter int COORD_BITS = 32,
    localparam int IN_W       = 3 * COORD_BITS,
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W      = 6 * COORD_BITS + 3 * ssve_pkg::CNT_W,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ssve_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ssve_pkg::WIN_W-1:0]       cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // point_x, point_y, point_z, zero fill
    input  logic [IN_TDATA_W-1:0]            s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // value_x, value_y, value_z, top_x, top_y, top_z,
    // picked_x, picked_y, picked_z, zero fill
    output logic [OUT_TDATA_W-1:0]           m_tdata,
    // kind
    output logic                             m_tuser,
    output logic                             m_tlast
);

    localparam int TAG_W = $bits(ssve_pkg::tag_t);
    localparam int Q_W   = IN_W + TAG_W;

    ssve_pkg::tag_t   f_tag;
    ssve_pkg::tag_t   q_tag;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    logic [Q_W-1:0]   q_wdata;
    logic [Q_W-1:0]   q_rdata;
    logic [OUT_W-1:0] payload;

    // Classifier: configuration and grid position.
    ssve_front #(
        .MAX_GRID (MAX_GRID)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tlast   (s_tlast),
        .s_tready  (s_tready),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_tag     (f_tag)
    );

    // Queue between classifier and result stage.
    assign q_wdata = {s_tdata[IN_W-1:0], f_tag};

    ssve_fifo #(
        .WIDTH (Q_W),
        .DEPTH (ssve_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .valid (q_valid)
    );

    assign q_tag = ssve_pkg::tag_t'(q_rdata[TAG_W-1:0]);

    // Result stage: bounding box and output register.
    ssve_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pts     (q_rdata[Q_W-1:TAG_W]),
        .q_tag     (q_tag),
        .q_pop     (q_pop),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_kind    (m_tuser),
        .m_run_end (m_tlast),
        .m_payload (payload)
    );

    assign m_tdata = OUT_TDATA_W'(payload);

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Strided subvolume extractor testbench
// Streams grid points into the extractor and checks every picked point and
// every end-of-volume summary against a cycle-free software copy of the block.
// Directed volumes cover the coordinate extremes, empty and clamped windows,
// zero and oversized sizes and steps, and a stream past the grid limit.
// Random volumes with random windows and random idling on both sides follow.
// A final stretch runs back to back with no idling.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_PERIOD        = 4;
    localparam int GRID_MAX          = 1024;
    localparam int COORD_W           = 32;
    localparam int IN_TDATA_W        = 96;
    localparam int OUT_TDATA_W       = 232;
    localparam int SETTLE_CYCLES     = 8;
    localparam int RANDOM_ITEMS      = 300;
    localparam int LONG_STREAM_ITEMS = 1030;
    localparam int TIMEOUT_NS        = 10_000_000;
    localparam int MAX_PRINTED       = 50;

    // Index outside the register list; writes to it must change nothing.
    localparam logic [ssve_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // One result item as it leaves the block.
    typedef struct packed {
        logic        kind;
        logic [31:0] value_x;
        logic [31:0] value_y;
        logic [31:0] value_z;
        logic [31:0] top_x;
        logic [31:0] top_y;
        logic [31:0] top_z;
        logic [10:0] picked_x;
        logic [10:0] picked_y;
        logic [10:0] picked_z;
        logic        run_end;
    } crop_result_t;

    // Block ports.
    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [ssve_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [ssve_pkg::WIN_W-1:0]       cfg_data = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    // point_x, point_y, point_z
    logic [IN_TDATA_W-1:0]            s_tdata = '0;
    logic                             s_tlast = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b1;
    // value_x, value_y, value_z, top_x, top_y, top_z,
    // picked_x, picked_y, picked_z, zero fill
    logic [OUT_TDATA_W-1:0]           m_tdata;
    // kind
    logic                             m_tuser;
    logic                             m_tlast;

    // Results still to come, oldest first.
    crop_result_t crop_results_q[$];

    // Register copies and grid walk state of the software copy.
    logic [10:0]        shadow_size_y;
    logic [10:0]        shadow_size_z;
    logic [31:0]        shadow_win_x;
    logic [31:0]        shadow_win_y;
    logic [31:0]        shadow_win_z;
    int unsigned        grid_px, grid_py, grid_pz;
    int unsigned        phase_px, phase_py, phase_pz;
    logic signed [31:0] low_bound[3];
    logic signed [31:0] high_bound[3];
    logic [10:0]        axis_hits[3];
    bit                 seen_pick;

    bit src_idle_on;
    bit sink_idle_on;
    int stall_left;
    int error_count;
    int random_points_sent;

    always #(CLK_PERIOD / 2) clk = ~clk;

    strided_subvolume_extract #(
        .MAX_GRID   (GRID_MAX),
        .COORD_BITS (COORD_W)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Window field helpers.
    function automatic int unsigned win_lo(input logic [31:0] w);
        return 32'(w[10:0]);
    endfunction

    function automatic int unsigned win_hi(input logic [31:0] w);
        return 32'(w[21:11]);
    endfunction

    function automatic int unsigned win_stride(input logic [31:0] w);
        return (w[31:22] == 10'd0) ? 32'd1 : 32'(w[31:22]);
    endfunction

    function automatic logic [31:0] window(input logic [31:0] lo, hi, stride);
        return {stride[9:0], hi[10:0], lo[10:0]};
    endfunction

    // A size of zero acts as one and sizes above the grid limit are capped.
    function automatic int unsigned grid_len(input logic [10:0] s);
        if (s == 11'd0)
            return 1;
        if (s > GRID_MAX)
            return GRID_MAX;
        return 32'(s);
    endfunction

    // A position is inside the window when it lies in [start, end) and its
    // stride phase is zero; the end never reaches past the axis length.
    function automatic bit on_axis(input int unsigned p, ph, input logic [31:0] w,
                                   input int unsigned lim);
        int unsigned stop;
        stop = win_hi(w);
        if (stop > lim)
            stop = lim;
        return p >= win_lo(w) && p < stop && ph == 0;
    endfunction

    function automatic int unsigned step_phase(input int unsigned np, ph,
                                               input logic [31:0] w);
        if (np <= win_lo(w))
            return 0;
        return (ph + 1 >= win_stride(w)) ? 0 : ph + 1;
    endfunction

    // Add one awaited result behind the others.
    task automatic await_result(input crop_result_t r);
        crop_results_q.insert(crop_results_q.size(), r);
    endtask

    // Clear the grid walk, the bounds and the counts.
    task automatic clear_grid();
        grid_px = 0;
        grid_py = 0;
        grid_pz = 0;
        phase_px = 0;
        phase_py = 0;
        phase_pz = 0;
        for (int i = 0; i < 3; i++)
        begin
            low_bound[i] = '0;
            high_bound[i] = '0;
            axis_hits[i] = '0;
        end
        seen_pick = 1'b0;
    endtask

    task automatic reset_model();
        shadow_size_y = ssve_pkg::SIZE_RESET;
        shadow_size_z = ssve_pkg::SIZE_RESET;
        shadow_win_x = ssve_pkg::WINDOW_RESET;
        shadow_win_y = ssve_pkg::WINDOW_RESET;
        shadow_win_z = ssve_pkg::WINDOW_RESET;
        clear_grid();
    endtask

    // Move to the next grid point in raster order, z fastest. The x position
    // saturates rather than wraps.
    task automatic step_grid();
        if (grid_pz + 1 < grid_len(shadow_size_z))
        begin
            phase_pz = step_phase(grid_pz + 1, phase_pz, shadow_win_z);
            grid_pz++;
        end
        else
        begin
            grid_pz = 0;
            phase_pz = 0;
            if (grid_py + 1 < grid_len(shadow_size_y))
            begin
                phase_py = step_phase(grid_py + 1, phase_py, shadow_win_y);
                grid_py++;
            end
            else
            begin
                grid_py = 0;
                phase_py = 0;
                if (grid_px < ssve_pkg::POS_MAX)
                begin
                    phase_px = step_phase(grid_px + 1, phase_px, shadow_win_x);
                    grid_px++;
                end
            end
        end
    endtask

    // Work out the results of one accepted grid point and queue them.
    task automatic crop_and_bound(input logic [31:0] px, py, pz, input bit last);
        crop_result_t       r;
        logic signed [31:0] p[3];
        bit                 hx, hy, hz, fx, fy, fz;
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        hx = on_axis(grid_px, phase_px, shadow_win_x, GRID_MAX);
        hy = on_axis(grid_py, phase_py, shadow_win_y, grid_len(shadow_size_y));
        hz = on_axis(grid_pz, phase_pz, shadow_win_z, grid_len(shadow_size_z));

        if (hx && hy && hz)
        begin
            // An axis position counts once, at the first picked spot of the
            // other two axes.
            fx = grid_px == win_lo(shadow_win_x);
            fy = grid_py == win_lo(shadow_win_y);
            fz = grid_pz == win_lo(shadow_win_z);
            if (fy && fz && axis_hits[0] != ssve_pkg::POS_MAX)
                axis_hits[0]++;
            if (fx && fz && axis_hits[1] != ssve_pkg::POS_MAX)
                axis_hits[1]++;
            if (fx && fy && axis_hits[2] != ssve_pkg::POS_MAX)
                axis_hits[2]++;
            for (int i = 0; i < 3; i++)
            begin
                if (!seen_pick)
                begin
                    low_bound[i] = p[i];
                    high_bound[i] = p[i];
                end
                else
                begin
                    if (p[i] < low_bound[i])
                        low_bound[i] = p[i];
                    if (p[i] > high_bound[i])
                        high_bound[i] = p[i];
                end
            end
            seen_pick = 1'b1;
            r = '0;
            r.kind = ssve_pkg::KIND_POINT;
            r.value_x = px;
            r.value_y = py;
            r.value_z = pz;
            r.run_end = !last;
            await_result(r);
        end

        if (last)
        begin
            r = '0;
            r.kind = ssve_pkg::KIND_SUMMARY;
            r.value_x = low_bound[0];
            r.value_y = low_bound[1];
            r.value_z = low_bound[2];
            r.top_x = high_bound[0];
            r.top_y = high_bound[1];
            r.top_z = high_bound[2];
            r.picked_x = axis_hits[0];
            r.picked_y = axis_hits[1];
            r.picked_z = axis_hits[2];
            r.run_end = 1'b1;
            await_result(r);
            clear_grid();
        end
        else
        begin
            step_grid();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got, want);
        if (error_count < MAX_PRINTED)
            $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Send one grid point, called and returning at a falling edge. A random
    // gap may come first while sender idling is on.
    task automatic send_point(input logic [31:0] px, py, pz, input bit last);
        int gap;
        if (src_idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {pz, py, px};
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        crop_and_bound(px, py, pz, last);
        @(negedge clk);
    endtask

    // Stop sending and wait until every awaited result has arrived, then give
    // points that cause no result time to leave the pipeline.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (crop_results_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write one register; the caller drops cfg_we after its last write.
    task automatic write_reg(input logic [ssve_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        case (idx)
            ssve_pkg::CFG_SIZE_Y:   shadow_size_y = data[10:0];
            ssve_pkg::CFG_SIZE_Z:   shadow_size_z = data[10:0];
            ssve_pkg::CFG_WINDOW_X: shadow_win_x = data;
            ssve_pkg::CFG_WINDOW_Y: shadow_win_y = data;
            ssve_pkg::CFG_WINDOW_Z: shadow_win_z = data;
            default:                ;
        endcase
    endtask

    // Write all five registers; the block must be idle.
    task automatic configure(input logic [31:0] sy, sz, wx, wy, wz);
        write_reg(ssve_pkg::CFG_SIZE_Y, sy);
        write_reg(ssve_pkg::CFG_SIZE_Z, sz);
        write_reg(ssve_pkg::CFG_WINDOW_X, wx);
        write_reg(ssve_pkg::CFG_WINDOW_Y, wy);
        write_reg(ssve_pkg::CFG_WINDOW_Z, wz);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly small windows on small grids, sometimes an end past the grid, a
    // long stride or a fully random word.
    function automatic logic [31:0] random_window();
        logic [31:0] lo, hi, stride;
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        lo = $urandom_range(0, 4);
        hi = ($urandom_range(0, 5) == 0) ? 2047 : $urandom_range(0, 7);
        stride = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                             : $urandom_range(0, 3);
        return window(lo, hi, stride);
    endfunction

    // Sink side: random bursts of back pressure while sink idling is on.
    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left = stall_left - 1;
        else if (sink_idle_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 16);
        m_tready <= (stall_left == 0);
    end

    // Compare each accepted result with the oldest awaited one.
    always @(posedge clk)
    begin
        crop_result_t got;
        crop_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind = m_tuser;
            got.value_x = m_tdata[31:0];
            got.value_y = m_tdata[63:32];
            got.value_z = m_tdata[95:64];
            got.top_x = m_tdata[127:96];
            got.top_y = m_tdata[159:128];
            got.top_z = m_tdata[191:160];
            got.picked_x = m_tdata[202:192];
            got.picked_y = m_tdata[213:203];
            got.picked_z = m_tdata[224:214];
            got.run_end = m_tlast;
            if (crop_results_q.size() == 0)
            begin
                report_mismatch("item with none awaited, value_x", got.value_x, '0);
            end
            else
            begin
                want = crop_results_q.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch("kind", 32'(got.kind), 32'(want.kind));
                if (got.value_x !== want.value_x)
                    report_mismatch("value_x", got.value_x, want.value_x);
                if (got.value_y !== want.value_y)
                    report_mismatch("value_y", got.value_y, want.value_y);
                if (got.value_z !== want.value_z)
                    report_mismatch("value_z", got.value_z, want.value_z);
                if (got.top_x !== want.top_x)
                    report_mismatch("top_x", got.top_x, want.top_x);
                if (got.top_y !== want.top_y)
                    report_mismatch("top_y", got.top_y, want.top_y);
                if (got.top_z !== want.top_z)
                    report_mismatch("top_z", got.top_z, want.top_z);
                if (got.picked_x !== want.picked_x)
                    report_mismatch("picked_x", 32'(got.picked_x), 32'(want.picked_x));
                if (got.picked_y !== want.picked_y)
                    report_mismatch("picked_y", 32'(got.picked_y), 32'(want.picked_y));
                if (got.picked_z !== want.picked_z)
                    report_mismatch("picked_z", 32'(got.picked_z), 32'(want.picked_z));
                if (got.run_end !== want.run_end)
                    report_mismatch("run_end", 32'(got.run_end), 32'(want.run_end));
            end
        end
    end

    // Reset window: every point is picked, so the coordinate extremes reach
    // the bounds. The last point is picked too and causes two items.
    task automatic test_default_window();
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
    endtask

    // Start not below end on x: nothing is picked and the summary is all zero.
    // A write to an index outside the register list comes first.
    task automatic test_empty_window();
        settle();
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        configure(3, 2, window(4, 4, 1), window(0, 3, 1), window(0, 2, 1));
        for (int i = 0; i < 4; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), i == 3);
    endtask

    // Size zero on y, stride zero and an end past the grid on z, stride two
    // on x.
    task automatic test_step_and_size_zero();
        settle();
        configure(0, 5, window(1, 3, 2), window(0, 50, 1), window(1, 2047, 0));
        for (int i = 0; i < 15; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), i == 14);
    endtask

    // Oversized and largest sizes, the longest stride, a short volume.
    task automatic test_size_extremes();
        settle();
        configure(32'hFFFF_FFFF, 1024, window(0, 1, 1023), window(0, 2047, 1023),
                  window(0, 2047, 1023));
        for (int i = 0; i < 3; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), i == 2);
    endtask

    // One point per x plane, past the grid limit; picks stop at the clamped
    // x end.
    task automatic test_long_stream();
        settle();
        configure(1, 1, window(1020, 2047, 3), window(0, 1, 0), window(0, 1, 0));
        for (int i = 0; i < LONG_STREAM_ITEMS; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(),
                       i == LONG_STREAM_ITEMS - 1);
    endtask

    // One random volume: random grid and windows, mostly whole volumes, some
    // cut short or overrun, sometimes a pause and a register write midway.
    task automatic run_random_volume();
        int                             npts, split, i;
        logic [31:0]                    sy, sz;
        logic [ssve_pkg::CFG_IDX_W-1:0] idx;
        if ($urandom_range(0, 7) == 0)
        begin
            sy = $urandom;
            sz = $urandom;
        end
        else
        begin
            sy = $urandom_range(0, 6);
            sz = $urandom_range(0, 6);
        end
        settle();
        configure(sy, sz, random_window(), random_window(), random_window());
        src_idle_on = $urandom_range(0, 2) != 0;
        sink_idle_on = $urandom_range(0, 2) != 0;

        npts = grid_len(sy[10:0]) * grid_len(sz[10:0]) * $urandom_range(1, 4);
        if (npts > 64)
            npts = $urandom_range(1, 64);
        else if ($urandom_range(0, 5) == 0)
            npts = $urandom_range(1, npts + 4);
        split = ($urandom_range(0, 5) == 0) ? $urandom_range(0, npts - 1) : -1;

        for (i = 0; i < npts; i++)
        begin
            if (i == split)
            begin
                // Drain completely, then maybe change one register mid-volume.
                settle();
                if ($urandom_range(0, 1) == 1)
                begin
                    idx = ssve_pkg::CFG_IDX_W'($urandom_range(ssve_pkg::CFG_SIZE_Y,
                                                              ssve_pkg::CFG_WINDOW_Z));
                    if (idx == ssve_pkg::CFG_SIZE_Y || idx == ssve_pkg::CFG_SIZE_Z)
                        write_reg(idx, $urandom_range(0, 6));
                    else
                        write_reg(idx, random_window());
                    cfg_we <= 1'b0;
                end
            end
            send_point(rand_coord(), rand_coord(), rand_coord(), i == npts - 1);
        end
        random_points_sent += npts;
    endtask

    task automatic test_random_volumes();
        random_points_sent = 0;
        while (random_points_sent < RANDOM_ITEMS)
            run_random_volume();
    endtask

    // Whole volumes back to back at full rate, with no idling on either side.
    task automatic test_back_to_back();
        settle();
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        configure(3, 4, window(0, 3, 0), window(1, 4, 2), window(0, 4, 3));
        for (int v = 0; v < 4; v++)
            for (int i = 0; i < 24; i++)
                send_point(rand_coord(), rand_coord(), rand_coord(), i == 23);
    endtask

    initial
    begin
        error_count = 0;
        stall_left = 0;
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        reset_model();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_window();
        test_empty_window();
        test_step_and_size_zero();
        test_size_extremes();
        test_long_stream();
        test_random_volumes();
        test_back_to_back();
        settle();

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #TIMEOUT_NS;
        $display("FAILURE");
        $finish;
    end

endmodule
